// ===== hw/rtl/sm3_hash_core_defines.svh =====
// assertion macros used by the sm3 back end
`ifndef SM3_HASH_CORE_DEFINES_SVH
`define SM3_HASH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SM3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sm3_pkg.sv =====
// shared types, constants and helper functions of the sm3 hash core
`timescale 1ns / 1ps

package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;

    localparam logic [31:0] IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // one message word with its block tags
    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        tail;
        logic        final_blk;
    } t_beat;

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        logic [31:0] r;
        r = (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - (n % 32))));
        return r;
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

endpackage

// ===== hw/rtl/sm3_hash_core.sv =====
// sm3 hash core top level: front end, beat queue and compression engine
//
//  channel   direction  handshake           beat payload
//  message   in         i_valid / o_stall   i_message_word, i_first_block, i_final_block
//  digest    out        o_valid / i_stall   o_digest_word, o_word_index, o_last_word
//
//  a block of 16 beats is loaded into the window, then goes through the rounds and the
//  fold on the single shared round unit, which takes no new block until it is done;
//  a final block also sends its eight digest words before the next block is loaded
//  the queue keeps taking beats while rounds run, up to QUEUE_DEPTH of them
//  synchronous active-low reset loads the iv and empties queue and output register
//  output stall only holds the digest register and blocks further output
`timescale 1ns / 1ps

module sm3_hash_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_first_block,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    // beats tagged by the front end travel through the queue
    sm3_pkg::t_beat w_push_beat;
    sm3_pkg::t_beat w_head_beat;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;

    // counts words per block, marks the sixteenth
    sm3_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_first_block  (i_first_block),
        .i_final_block  (i_final_block),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_beat         (w_push_beat)
    );

    // decouples intake from the round engine
    sm3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_push_beat),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_beat  (w_head_beat)
    );

    // expansion, compression, chaining and digest output
    sm3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_beat        (w_head_beat),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// ===== hw/rtl/sm3_front.sv =====
// sm3 front end: takes message beats and tags the block boundary
`timescale 1ns / 1ps

module sm3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [31:0]   i_message_word,
    input  logic          i_first_block,
    input  logic          i_final_block,
    input  logic          i_full,
    output logic          o_push,
    output sm3_pkg::t_beat o_beat
);

    logic [3:0] r_word_count;
    logic [3:0] n_word_count;
    logic       w_tail;

    assign o_stall = i_full;
    assign o_push  = i_valid & ~i_full;
    assign w_tail  = (r_word_count == 4'd15);

    assign o_beat.word      = i_message_word;
    assign o_beat.first     = i_first_block;
    assign o_beat.tail      = w_tail;
    assign o_beat.final_blk = i_final_block & w_tail;

    assign n_word_count = o_push ? r_word_count + 4'd1 : r_word_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= 4'd0;
        end else begin
            r_word_count <= n_word_count;
        end
    end

endmodule

// ===== hw/rtl/sm3_fifo.sv =====
// sm3 beat queue between front end and compression engine
`timescale 1ns / 1ps

module sm3_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sm3_pkg::t_beat i_beat,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sm3_pkg::t_beat o_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    sm3_pkg::t_beat r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_beat  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/sm3_back.sv =====
// sm3 back end: expansion window, 64 serial rounds, fold and digest output
`timescale 1ns / 1ps
`include "sm3_hash_core_defines.svh"

module sm3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sm3_pkg::t_beat i_beat,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word
);

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_FOLD, S_EMIT} t_state;

    t_state      r_state;
    logic [31:0] r_cv  [8];
    logic [31:0] r_v   [8];
    logic [31:0] r_win [16];
    logic [31:0] r_tj;
    logic [5:0]  r_round;
    logic        r_final;
    logic [2:0]  r_idx;

    logic [31:0] w_new;
    logic [31:0] w_a12, w_ss1, w_ss2, w_ff, w_gg, w_tt1, w_tt2;
    logic        w_high;
    logic        w_out_free;

    assign o_pop      = (r_state == S_LOAD) && !i_empty;
    assign w_out_free = !o_valid || !i_stall;
    assign w_high     = (r_round[5:4] != 2'd0);

    // next expanded word and one compression round
    always_comb begin
        w_new = sm3_pkg::perm1(r_win[0] ^ r_win[7] ^ sm3_pkg::rol(r_win[13], 15))
              ^ sm3_pkg::rol(r_win[3], 7) ^ r_win[10];
        w_a12 = sm3_pkg::rol(r_v[0], 12);
        w_ss1 = sm3_pkg::rol(w_a12 + r_v[4] + r_tj, 7);
        w_ss2 = w_ss1 ^ w_a12;
        if (w_high) begin
            w_ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            w_gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end else begin
            w_ff = r_v[0] ^ r_v[1] ^ r_v[2];
            w_gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end
        w_tt1 = w_ff + r_v[3] + w_ss2 + (r_win[0] ^ r_win[4]);
        w_tt2 = w_gg + r_v[7] + w_ss1 + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            o_valid <= 1'b0;
            r_round <= '0;
            r_idx   <= '0;
            r_final <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_cv[k] <= sm3_pkg::IV[k];
            end
        end else begin
            // emit state owns the valid flag while it runs
            if (o_valid && !i_stall && r_state != S_EMIT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        for (int k = 0; k < 15; k++) begin
                            r_win[k] <= r_win[k+1];
                        end
                        r_win[15] <= i_beat.word;
                        if (i_beat.first) begin
                            for (int k = 0; k < 8; k++) begin
                                r_cv[k] <= sm3_pkg::IV[k];
                            end
                        end
                        if (i_beat.tail) begin
                            for (int k = 0; k < 8; k++) begin
                                r_v[k] <= i_beat.first ? sm3_pkg::IV[k] : r_cv[k];
                            end
                            r_final <= i_beat.final_blk;
                            r_round <= '0;
                            r_tj    <= sm3_pkg::T_LOW;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_v[0] <= w_tt1;
                    r_v[1] <= r_v[0];
                    r_v[2] <= sm3_pkg::rol(r_v[1], 9);
                    r_v[3] <= r_v[2];
                    r_v[4] <= sm3_pkg::perm0(w_tt2);
                    r_v[5] <= r_v[4];
                    r_v[6] <= sm3_pkg::rol(r_v[5], 19);
                    r_v[7] <= r_v[6];
                    for (int k = 0; k < 15; k++) begin
                        r_win[k] <= r_win[k+1];
                    end
                    r_win[15] <= w_new;
                    r_tj <= (r_round == 6'd15) ? sm3_pkg::rol(sm3_pkg::T_HIGH, 16)
                                               : sm3_pkg::rol(r_tj, 1);
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int k = 0; k < 8; k++) begin
                        r_cv[k] <= r_cv[k] ^ r_v[k];
                    end
                    r_idx   <= '0;
                    r_state <= r_final ? S_EMIT : S_LOAD;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        o_valid       <= 1'b1;
                        o_digest_word <= r_cv[r_idx];
                        o_word_index  <= r_idx;
                        o_last_word   <= (r_idx == 3'd7);
                        r_idx         <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `SM3_ASSERT_NOW(a_last_is_eighth, o_valid && o_last_word, o_word_index == 3'd7,
        "last digest beat without index seven")
    `SM3_ASSERT_NEXT(a_round_wraps_to_fold, r_state == S_ROUND && r_round == 6'd63,
        r_state == S_FOLD, "round counter did not hand over to fold")
    `SM3_ASSERT_NOW(a_pop_only_in_load, o_pop, r_state == S_LOAD && !i_empty,
        "queue popped outside load")

endmodule

// ===== test/sm3_digest_checker.sv =====
// checker for the sm3 hash core: predicts digest beats and compares them
`timescale 1ns / 1ps

module sm3_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_first_block,
    input  logic        i_final_block,
    input  logic        i_out_valid,
    input  logic        i_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_errors,
    output int          o_pending,
    output int          o_digests
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    int unsigned  fill;
    t_digest_beat digest_q [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    task automatic compress_into_chain();
        logic [31:0] w [68];
        logic [31:0] wx [64];
        logic [31:0] v [8];
        logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
        for (int j = 0; j < 64; j++) wx[j] = w[j] ^ w[j+4];
        for (int j = 0; j < 8; j++) v[j] = chain[j];
        for (int j = 0; j < 64; j++) begin
            t = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
            a12 = rotl(v[0], 12);
            ss1 = rotl(a12 + v[4] + rotl(t, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end else begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1 = ff + v[3] + ss2 + wx[j];
            tt2 = gg + v[7] + ss1 + w[j];
            v[3] = v[2]; v[2] = rotl(v[1], 9); v[1] = v[0]; v[0] = tt1;
            v[7] = v[6]; v[6] = rotl(v[5], 19); v[5] = v[4]; v[4] = p0(tt2);
        end
        for (int j = 0; j < 8; j++) chain[j] ^= v[j];
    endtask

    task automatic take_message_beat(input logic [31:0] word, input logic first,
                                     input logic fin);
        t_digest_beat d;
        if (first) for (int j = 0; j < 8; j++) chain[j] = sm3_pkg::IV[j];
        blk[fill] = word;
        if (fill != 15) begin
            fill++;
            return;
        end
        fill = 0;
        compress_into_chain();
        if (fin) begin
            for (int k = 0; k < 8; k++) begin
                d.word = chain[k];
                d.idx  = 3'(k);
                d.last = (k == 7);
                digest_q.push_back(d);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_beat exp_b;
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) chain[j] = sm3_pkg::IV[j];
            fill = 0;
            digest_q.delete();
            o_errors = 0;
            o_digests = 0;
        end else begin
            if (i_valid && !i_in_stall)
                take_message_beat(i_message_word, i_first_block, i_final_block);
            if (i_out_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected digest beat %h idx %0d last %0b", $time,
                             i_digest_word, i_word_index, i_last_word);
                end else begin
                    exp_b = digest_q.pop_front();
                    o_digests++;
                    if (exp_b.word !== i_digest_word || exp_b.idx !== i_word_index
                        || exp_b.last !== i_last_word) begin
                        o_errors++;
                        $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                                 $time, exp_b.word, exp_b.idx, exp_b.last,
                                 i_digest_word, i_word_index, i_last_word);
                    end
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule

// ===== test/sm3_hash_core_tb.sv =====
// testbench top for the sm3 hash core: stimulus, idling and verdict
`timescale 1ns / 1ps

module sm3_hash_core_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic        i_first_block = 1'b0;
    logic        i_final_block = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    int          errors, pending, digests;
    int          send_idle_pct, recv_idle_pct;
    int          beats_sent;

    always #4 i_clk = ~i_clk;

    sm3_hash_core i_dut (.*);

    sm3_digest_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_message_word,
        .i_first_block, .i_final_block, .i_out_valid(o_valid), .i_stall,
        .i_digest_word(o_digest_word), .i_word_index(o_word_index),
        .i_last_word(o_last_word), .o_errors(errors), .o_pending(pending),
        .o_digests(digests)
    );

    // receiver stalls at random, changed on the falling edge
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    // one message beat: optional idle gap, then hold until accepted
    // valid stays up after acceptance until the next beat or an idle cycle replaces it
    task automatic send_beat(input logic [31:0] w, input logic first, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_message_word <= w;
        i_first_block  <= first;
        i_final_block  <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // a 16-beat block; words come from a pattern selector
    task automatic send_block(input logic first, input logic fin, input int pat);
        logic [31:0] w;
        for (int k = 0; k < 16; k++) begin
            case (pat)
                0: w = 32'h0;
                1: w = 32'hffff_ffff;
                2: w = 32'h1 << (k * 2);
                default: w = $urandom;
            endcase
            // stray flags on inner beats: first restarts the chain, final is ignored
            send_beat(w, (k == 0) ? first : (pat == 4 && k == 7),
                      (k == 15) ? fin : (pat == 5 && k < 15 && k[0]));
        end
    endtask

    task automatic drain_digests();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        beats_sent = 0;
        send_idle_pct = 28;
        recv_idle_pct = 66;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes and chained blocks
        send_block(1'b1, 1'b1, 0);
        send_block(1'b1, 1'b0, 1);
        send_block(1'b0, 1'b1, 2);
        // pause until every digest beat is out
        drain_digests();

        // random messages of one or two blocks of random words, some with stray flags
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 66 : 0;
            recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 28 : 0;
            for (int m = 0; m < 3; m++) begin
                int nb;
                nb = $urandom_range(1, 2);
                for (int b = 0; b < nb; b++)
                    send_block(b == 0 || $urandom_range(9) == 0, b == nb - 1,
                               $urandom_range(3, 12));
            end
        end

        drain_digests();
        $display("sent %0d message beats, checked %0d digest beats", beats_sent, digests);
        $display("idling: sender-heavy, receiver-heavy and none; stray flags mid-block");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_front.sv
hw/rtl/sm3_fifo.sv
hw/rtl/sm3_back.sv
hw/rtl/sm3_hash_core.sv
test/sm3_digest_checker.sv
test/sm3_hash_core_tb.sv
